[hdl/rfo_pkg.sv]
package rfo_pkg;

	// ring geometry
	localparam int DEPTH     = 16;
	localparam int IDX_BITS  = $clog2(DEPTH);
	localparam int WORD_BITS = 32;

	// fill level of a full ring: one slot always stays free
	localparam logic [IDX_BITS-1:0] IDX_MAX = IDX_BITS'(DEPTH - 1);

	// operation codes carried in kind
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// status codes
	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FAIL = 1'b1;

	// stage one: result of the pointer update, awaiting the RAM read data
	typedef struct packed {
		logic                valid;
		logic                rd_ok;
		logic                status;
		logic [IDX_BITS-1:0] occupancy;
	} rfo_s1_t;

endpackage

[hdl/rfo_if.sv]
interface rfo_in_if import rfo_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 kind;
	logic [WORD_BITS-1:0] write_data;
	logic                 force_req;

	modport source(output valid, kind, write_data, force_req, input ready);
	modport sink(input valid, kind, write_data, force_req, output ready);
endinterface

interface rfo_out_if import rfo_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [WORD_BITS-1:0] read_data;
	logic                 status;
	logic [IDX_BITS-1:0]  occupancy;

	modport source(output valid, read_data, status, occupancy, input ready);
	modport sink(input valid, read_data, status, occupancy, output ready);
endinterface

[hdl/rfo_ram.sv]
module rfo_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, held when idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/rfo_ctrl.sv]
module rfo_ctrl import rfo_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	rfo_in_if.sink               in_ch,
	input  logic                 s1_take,
	output rfo_s1_t              s1,
	output logic                 ram_we,
	output logic [IDX_BITS-1:0]  ram_waddr,
	output logic [WORD_BITS-1:0] ram_wdata,
	output logic                 ram_re,
	output logic [IDX_BITS-1:0]  ram_raddr
);

	logic [IDX_BITS-1:0] head_q, tail_q;
	logic [IDX_BITS-1:0] head_d, tail_d;
	logic [IDX_BITS-1:0] fill;
	logic                full, empty, acc;
	rfo_s1_t             s1_q, s1_d;

	assign fill  = tail_q - head_q;
	assign full  = (fill == IDX_MAX);
	assign empty = (head_q == tail_q);

	// stage one frees up when its result moves on
	assign in_ch.ready = !s1_q.valid || s1_take;
	assign acc         = in_ch.valid && in_ch.ready;

	// pointer update and RAM access for the accepted beat
	always_comb begin
		head_d       = head_q;
		tail_d       = tail_q;
		ram_we       = 1'b0;
		ram_re       = 1'b0;
		s1_d.valid   = acc;
		s1_d.rd_ok   = 1'b0;
		s1_d.status  = ST_OK;
		if (acc) begin
			if (in_ch.kind == OP_WRITE) begin
				if (full) begin
					s1_d.status = ST_FAIL;
					if (in_ch.force_req) begin
						ram_we = 1'b1;
						head_d = head_q + 1'b1;
						tail_d = tail_q + 1'b1;
					end
				end else begin
					ram_we = 1'b1;
					tail_d = tail_q + 1'b1;
				end
			end else begin
				if (empty) begin
					s1_d.status = ST_FAIL;
				end else begin
					ram_re     = 1'b1;
					s1_d.rd_ok = 1'b1;
					head_d     = head_q + 1'b1;
				end
			end
		end
		s1_d.occupancy = tail_d - head_d;
	end

	assign ram_waddr = tail_q;
	assign ram_wdata = in_ch.write_data;
	assign ram_raddr = head_q;

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			head_q <= head_d;
			tail_q <= tail_d;
		end
	end

	// stage one register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q <= '0;
		end else if (in_ch.ready) begin
			s1_q <= s1_d;
		end
	end

	assign s1 = s1_q;

`ifndef SYNTHESIS
	// a write into a full ring reports full and stays full
	a_full_write: assert property (@(posedge clk) disable iff (!arst_n)
		acc && in_ch.kind == OP_WRITE && full
		|=> s1_q.status == ST_FAIL && s1_q.occupancy == IDX_MAX)
		else $error("full write did not report full");

	// a read from a non-empty ring fetches and shrinks the level by one
	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		acc && in_ch.kind == OP_READ && !empty
		|=> s1_q.rd_ok && s1_q.occupancy == $past(fill) - 1'b1)
		else $error("read did not take the oldest entry");

	// a stalled stage-one result holds
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_q.valid && !s1_take |=> $stable(s1_q))
		else $error("stage one changed while stalled");
`endif

endmodule

[hdl/ring_fifo_with_overwrite_top.sv]
// Ring FIFO of WORD_BITS-bit words in a single DEPTH-entry synchronous RAM, holding at
// most DEPTH-1 entries. Each input beat is a write or a read and yields one result beat
// with read data, status and the fill level after the operation. One beat is accepted
// per cycle while stage one can move on; a result passes from the registered RAM read and
// stage one into the output register. The head and tail pointers update in the
// cycle of acceptance, so back-to-back beats need no interlock. Up to two results may
// wait under output back-pressure before the input stalls. No clearing pass after reset.
module ring_fifo_with_overwrite_top import rfo_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	rfo_in_if.sink   in_ch,
	rfo_out_if.source out_ch
);

	rfo_s1_t              s1;
	logic                 take;
	logic                 ram_we, ram_re;
	logic [IDX_BITS-1:0]  ram_waddr, ram_raddr;
	logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

	logic                 out_valid_q;
	logic [WORD_BITS-1:0] read_data_q;
	logic                 status_q;
	logic [IDX_BITS-1:0]  occupancy_q;

	rfo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.s1_take   (take),
		.s1        (s1),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr)
	);

	rfo_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// output register loads when empty or being drained
	assign take = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= s1.valid;
		end
	end

	// payload: read data only on a successful read
	always_ff @(posedge clk) begin
		if (take && s1.valid) begin
			read_data_q <= s1.rd_ok ? ram_rdata : '0;
			status_q    <= s1.status;
			occupancy_q <= s1.occupancy;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.read_data = read_data_q;
	assign out_ch.status    = status_q;
	assign out_ch.occupancy = occupancy_q;

`ifndef SYNTHESIS
	// a failed beat never carries data
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == ST_FAIL |-> read_data_q == '0)
		else $error("failed beat carries data");

	// a result waiting in stage one behind a stalled output blocks the input
	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		s1.valid && !take |-> !in_ch.ready)
		else $error("input taken while stage one is blocked");

	// an undrained output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready
		|=> out_valid_q && $stable(read_data_q) && $stable(status_q)
			&& $stable(occupancy_q))
		else $error("output beat changed while stalled");
`endif

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
	import rfo_pkg::*;

	localparam int RANDOM_ACCESSES = 1000;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int DRAIN_CYCLES    = 10;
	localparam int MAX_WAIT        = 18;

	// one result beat as the ring reports it
	typedef struct packed {
		logic [WORD_BITS-1:0] read_data;
		logic                 status;
		logic [IDX_BITS-1:0]  occupancy;
	} ring_result_t;

	// directed access; exp is used only where typed is set
	typedef struct packed {
		logic         kind;
		logic [31:0]  wdata;
		logic         force_flag;
		logic         typed;
		ring_result_t exp;
	} access_row_t;

	localparam int NUM_ROWS = 25;

	// directed table: reset state, data extremes, fill to the brim, full with and without
	// overwrite, force on a non-full write and on a read
	localparam access_row_t ACCESS_ROWS [NUM_ROWS] = '{
		'{OP_READ,  32'h0000_0000, 1'b0, 1'b1, '{32'h0, ST_FAIL, 4'd0}},
		'{OP_WRITE, 32'h0000_0000, 1'b0, 1'b1, '{32'h0, ST_OK,   4'd1}},
		'{OP_WRITE, 32'hFFFF_FFFF, 1'b0, 1'b1, '{32'h0, ST_OK,   4'd2}},
		'{OP_READ,  32'h0000_0000, 1'b0, 1'b1, '{32'h0, ST_OK,   4'd1}},
		'{OP_READ,  32'h0000_0000, 1'b0, 1'b1, '{32'hFFFF_FFFF, ST_OK, 4'd0}},
		'{OP_READ,  32'hFFFF_FFFF, 1'b1, 1'b1, '{32'h0, ST_FAIL, 4'd0}},
		'{OP_WRITE, 32'h8000_0000, 1'b0, 1'b1, '{32'h0, ST_OK,   4'd1}},
		'{OP_WRITE, 32'h0000_0001, 1'b0, 1'b1, '{32'h0, ST_OK,   4'd2}},
		'{OP_WRITE, 32'hA5A5_A5A5, 1'b0, 1'b1, '{32'h0, ST_OK,   4'd3}},
		'{OP_WRITE, 32'h5A5A_5A5A, 1'b0, 1'b1, '{32'h0, ST_OK,   4'd4}},
		'{OP_WRITE, 32'h3F80_0000, 1'b0, 1'b1, '{32'h0, ST_OK,   4'd5}},
		'{OP_WRITE, 32'hBF80_0000, 1'b0, 1'b1, '{32'h0, ST_OK,   4'd6}},
		'{OP_WRITE, 32'h7F80_0000, 1'b0, 1'b1, '{32'h0, ST_OK,   4'd7}},
		'{OP_WRITE, 32'h7FC0_0001, 1'b0, 1'b1, '{32'h0, ST_OK,   4'd8}},
		'{OP_WRITE, 32'h0000_FFFF, 1'b0, 1'b1, '{32'h0, ST_OK,   4'd9}},
		'{OP_WRITE, 32'hFFFF_0000, 1'b0, 1'b1, '{32'h0, ST_OK,   4'd10}},
		'{OP_WRITE, 32'h0F0F_0F0F, 1'b0, 1'b1, '{32'h0, ST_OK,   4'd11}},
		'{OP_WRITE, 32'hF0F0_F0F0, 1'b0, 1'b1, '{32'h0, ST_OK,   4'd12}},
		'{OP_WRITE, 32'h1234_5678, 1'b0, 1'b1, '{32'h0, ST_OK,   4'd13}},
		'{OP_WRITE, 32'h8765_4321, 1'b0, 1'b1, '{32'h0, ST_OK,   4'd14}},
		'{OP_WRITE, 32'h7FFF_FFFF, 1'b0, 1'b1, '{32'h0, ST_OK,   4'd15}},
		'{OP_WRITE, 32'hDEAD_BEEF, 1'b0, 1'b1, '{32'h0, ST_FAIL, 4'd15}},
		'{OP_WRITE, 32'hCAFE_F00D, 1'b1, 1'b1, '{32'h0, ST_FAIL, 4'd15}},
		'{OP_READ,  32'h0000_0000, 1'b1, 1'b0, '0},
		'{OP_WRITE, 32'h0BAD_CAFE, 1'b1, 1'b0, '0}
	};

	logic clk;
	logic arst_n;

	rfo_in_if  in_ch();
	rfo_out_if out_ch();

	ring_fifo_with_overwrite_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// mirror of the ring
	logic [WORD_BITS-1:0] ring_mem [DEPTH];
	logic [IDX_BITS-1:0]  head_ptr;
	logic [IDX_BITS-1:0]  tail_ptr;

	ring_result_t pending_results [$];
	int           fault_count;
	int           cycle_count;
	bit           no_idle;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// apply one access to the mirror and work out its result
	task automatic ring_apply(input logic kind, input logic [WORD_BITS-1:0] wdata,
			input logic force_flag, output ring_result_t res);
		logic [IDX_BITS-1:0] fill;
		res        = '0;
		res.status = ST_OK;
		fill       = tail_ptr - head_ptr;
		if (kind == OP_WRITE) begin
			if (fill == IDX_MAX) begin
				res.status = ST_FAIL;
				// overwrite drops the oldest entry
				if (force_flag) begin
					head_ptr           = head_ptr + 1'b1;
					ring_mem[tail_ptr] = wdata;
					tail_ptr           = tail_ptr + 1'b1;
				end
			end else begin
				ring_mem[tail_ptr] = wdata;
				tail_ptr           = tail_ptr + 1'b1;
			end
		end else begin
			if (fill == '0) begin
				res.status = ST_FAIL;
			end else begin
				res.read_data = ring_mem[head_ptr];
				head_ptr      = head_ptr + 1'b1;
			end
		end
		res.occupancy = tail_ptr - head_ptr;
	endtask

	// drive one access beat; call and return at a rising edge
	task automatic send_access(input logic kind, input logic [WORD_BITS-1:0] wdata,
			input logic force_flag, input logic typed, input ring_result_t typed_res);
		int           gap;
		ring_result_t res;
		gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.kind       <= kind;
		in_ch.write_data <= wdata;
		in_ch.force_req  <= force_flag;
		@(negedge clk);
		while (!in_ch.ready) @(negedge clk);
		@(posedge clk);
		ring_apply(kind, wdata, force_flag, res);
		pending_results.push_back(typed ? typed_res : res);
	endtask

	// stimulus
	initial begin
		int                   n;
		int                   write_pct;
		logic                 kind;
		logic [WORD_BITS-1:0] wdata;
		int                   sel;
		arst_n           = 1'b0;
		fault_count      = 0;
		no_idle          = 1'b0;
		head_ptr         = '0;
		tail_ptr         = '0;
		write_pct        = 50;
		in_ch.valid      <= 1'b0;
		in_ch.kind       <= OP_WRITE;
		in_ch.write_data <= '0;
		in_ch.force_req  <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (n = 0; n < NUM_ROWS; n++) begin
			send_access(ACCESS_ROWS[n].kind, ACCESS_ROWS[n].wdata, ACCESS_ROWS[n].force_flag,
				ACCESS_ROWS[n].typed, ACCESS_ROWS[n].exp);
		end

		// random traffic: write bias swings so the ring runs both full and empty
		for (n = 0; n < RANDOM_ACCESSES; n++) begin
			if (n % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: begin
						write_pct = 15;
					end
					1: begin
						write_pct = 50;
					end
					default: begin
						write_pct = 85;
					end
				endcase
			end
			if (n % 64 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			kind = ($urandom_range(0, 99) < write_pct) ? OP_WRITE : OP_READ;
			sel  = $urandom_range(0, 7);
			if (sel == 0)
				wdata = '0;
			else if (sel == 1)
				wdata = '1;
			else
				wdata = $urandom();
			send_access(kind, wdata, 1'($urandom_range(0, 1)), 1'b0, '0);
		end
		in_ch.valid <= 1'b0;

		// drain
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// result side: random back-pressure, compare each beat with the oldest expectation
	initial begin
		int           stall;
		ring_result_t exp;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(negedge clk);
			while (!out_ch.valid) @(negedge clk);
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result beat read_data %h status %b occupancy %0d",
					$time, out_ch.read_data, out_ch.status, out_ch.occupancy);
				fault_count++;
			end else begin
				exp = pending_results.pop_front();
				if (out_ch.read_data !== exp.read_data) begin
					$display("%0t: read_data expected %h actual %h",
						$time, exp.read_data, out_ch.read_data);
					fault_count++;
				end
				if (out_ch.status !== exp.status) begin
					$display("%0t: status expected %b actual %b",
						$time, exp.status, out_ch.status);
					fault_count++;
				end
				if (out_ch.occupancy !== exp.occupancy) begin
					$display("%0t: occupancy expected %0d actual %0d",
						$time, exp.occupancy, out_ch.occupancy);
					fault_count++;
				end
			end
			@(posedge clk);
		end
	end

endmodule

[filelist.f]
hdl/rfo_pkg.sv
hdl/rfo_if.sv
hdl/rfo_ram.sv
hdl/rfo_ctrl.sv
hdl/ring_fifo_with_overwrite_top.sv
verif/tb.sv
